FILE: sv/lfra_pkg.sv
// ----------------------------------------------------------------------------
// lfra_pkg
// Shared types and constants for the lowest free room allocator.
// ----------------------------------------------------------------------------
package lfra_pkg;

  // rooms examined per free-map word
  localparam int CHUNK   = 8;
  localparam int CHUNK_W = 3;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_NOROOM = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    EV_ARRIVE = 1'b0,
    EV_DEPART = 1'b1
  } event_t;

  typedef struct packed {
    logic       func;
    logic [7:0] customer;
  } in_t;

  typedef struct packed {
    logic [8:0] room;
    logic [8:0] occupancy;
    logic [8:0] peak;
    status_t    status;
  } out_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HELD,
    S_SCAN,
    S_FREE,
    S_FINISH
  } state_t;

  // result of searching one free-map word
  typedef struct packed {
    logic               found;
    logic [CHUNK_W-1:0] pos;
  } pick_t;

endpackage

FILE: sv/lfra_ram.sv
// ----------------------------------------------------------------------------
// lfra_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lfra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/lfra_pick.sv
// ----------------------------------------------------------------------------
// lfra_pick
// Finds the lowest free room in one free-map word, ignoring rooms past the end.
// ----------------------------------------------------------------------------
module lfra_pick #(
  parameter int ROOMS = 256,
  parameter int MA_W  = 5
) (
  input  logic [lfra_pkg::CHUNK-1:0] occ,
  input  logic [MA_W-1:0]            idx,
  output lfra_pkg::pick_t            pick
);
  import lfra_pkg::*;

  logic [CHUNK-1:0] free_bits;

  always_comb begin
    for (int b = 0; b < CHUNK; b++) begin
      free_bits[b] = !occ[b] && (32'({idx, CHUNK_W'(b)}) < ROOMS);
    end
  end

  always_comb begin
    pick.found = 1'b0;
    pick.pos   = '0;
    for (int b = CHUNK - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        pick.found = 1'b1;
        pick.pos   = CHUNK_W'(b);
      end
    end
  end

endmodule

FILE: sv/lowest_free_room_allocator.sv
// ----------------------------------------------------------------------------
// lowest_free_room_allocator
// Gives each arriving customer the lowest-numbered free room and frees it on
// departure, reporting room, occupancy, peak occupancy and status per event.
// ----------------------------------------------------------------------------
// One event is handled at a time. After reset the block clears its two
// memories with in_stall high. Then an out-of-range customer goes straight to
// the result; other events first read the room held, and a departure that
// frees a room then updates the free map and the table. A new arrival searches
// the free map one 8-room word per cycle. Event throughput is set by the
// single-read free-map memory and the one shared word search. Results sit in
// an output register until taken; a new result waits while the previous one
// is stalled.
// ----------------------------------------------------------------------------
module lowest_free_room_allocator #(
  parameter int ROOMS     = 256,
  parameter int CUSTOMERS = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  lfra_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output lfra_pkg::out_t  out_data
);
  import lfra_pkg::*;

  // room numbers are 1-based, so they need room for ROOMS itself
  localparam int RM_W  = $clog2(ROOMS + 1);
  localparam int HA_W  = (CUSTOMERS > 1) ? $clog2(CUSTOMERS) : 1;
  localparam int MAP_D = (ROOMS + CHUNK - 1) / CHUNK;
  localparam int MA_W  = (MAP_D > 1) ? $clog2(MAP_D) : 1;
  localparam int CLR_D = (CUSTOMERS > MAP_D) ? CUSTOMERS : MAP_D;
  localparam int CLR_W = (CLR_D > 1) ? $clog2(CLR_D) : 1;

  // sequencer and work registers
  state_t           state_r, state_nxt;
  logic [CLR_W-1:0] clr_r, clr_nxt;
  logic             func_r, func_nxt;
  logic [HA_W-1:0]  cust_r, cust_nxt;
  logic [RM_W-1:0]  held_r, held_nxt;
  logic [RM_W-1:0]  room_r, room_nxt;
  status_t          stat_r, stat_nxt;
  logic [MA_W-1:0]  idx_r, idx_nxt;
  logic [RM_W-1:0]  use_r, use_nxt;
  logic [RM_W-1:0]  peak_r, peak_nxt;

  // output register
  logic             ovalid_r, ovalid_nxt;
  out_t             odata_r, odata_nxt;

  // memory ports
  logic             held_we;
  logic [HA_W-1:0]  held_waddr, held_raddr;
  logic [RM_W-1:0]  held_wdata, held_rdata;
  logic             map_we;
  logic [MA_W-1:0]  map_waddr, map_raddr;
  logic [CHUNK-1:0] map_wdata, map_rdata;

  pick_t            pick;

  // departure: word and bit of the held room
  logic [RM_W+2:0]  hm1;
  logic [MA_W-1:0]  free_idx;
  logic [CHUNK-1:0] free_bit;
  logic [CHUNK-1:0] take_bit;
  logic [RM_W-1:0]  new_room;
  logic [RM_W-1:0]  use_inc;
  logic             cust_bad;
  logic             in_take;

  // customer -> room table, zero means no room held
  lfra_ram #(.WIDTH(RM_W), .DEPTH(CUSTOMERS)) u_held (
    .clk   (clk),
    .we    (held_we),
    .waddr (held_waddr),
    .wdata (held_wdata),
    .raddr (held_raddr),
    .rdata (held_rdata)
  );

  // occupied-room bitmap, CHUNK rooms per word
  lfra_ram #(.WIDTH(CHUNK), .DEPTH(MAP_D)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // shared word search, reused for every word of the scan
  lfra_pick #(.ROOMS(ROOMS), .MA_W(MA_W)) u_pick (
    .occ  (map_rdata),
    .idx  (idx_r),
    .pick (pick)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  assign cust_bad  = (32'(in_data.customer) >= CUSTOMERS);
  assign hm1       = (RM_W + 3)'(held_r) - (RM_W + 3)'(1);
  assign free_idx  = MA_W'(hm1 >> CHUNK_W);
  assign free_bit  = CHUNK'(1) << hm1[CHUNK_W-1:0];
  assign take_bit  = CHUNK'(1) << pick.pos;
  assign new_room  = RM_W'({idx_r, pick.pos}) + RM_W'(1);
  assign use_inc   = use_r + RM_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      use_r    <= '0;
      peak_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      use_r    <= use_nxt;
      peak_r   <= peak_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // payload and per-transaction work registers
  always_ff @(posedge clk) begin
    func_r  <= func_nxt;
    cust_r  <= cust_nxt;
    held_r  <= held_nxt;
    room_r  <= room_nxt;
    stat_r  <= stat_nxt;
    idx_r   <= idx_nxt;
    odata_r <= odata_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    func_nxt   = func_r;
    cust_nxt   = cust_r;
    held_nxt   = held_r;
    room_nxt   = room_r;
    stat_nxt   = stat_r;
    idx_nxt    = idx_r;
    use_nxt    = use_r;
    peak_nxt   = peak_r;
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;

    held_we    = 1'b0;
    held_waddr = cust_r;
    held_wdata = '0;
    held_raddr = cust_r;
    map_we     = 1'b0;
    map_waddr  = idx_r;
    map_wdata  = '0;
    map_raddr  = idx_r;

    // a waiting result leaves when the far side takes it
    if (ovalid_r && !out_stall) begin
      ovalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        // one entry of each memory per cycle
        held_we    = (32'(clr_r) < CUSTOMERS);
        held_waddr = HA_W'(clr_r);
        map_we     = (32'(clr_r) < MAP_D);
        map_waddr  = MA_W'(clr_r);
        clr_nxt    = clr_r + CLR_W'(1);
        if (32'(clr_r) == CLR_D - 1) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        // start the table read on the accepting edge
        held_raddr = HA_W'(in_data.customer);
        if (in_take) begin
          func_nxt = in_data.func;
          cust_nxt = HA_W'(in_data.customer);
          room_nxt = '0;
          if (cust_bad) begin
            stat_nxt  = ST_NOROOM;
            state_nxt = S_FINISH;
          end else begin
            stat_nxt  = ST_OK;
            state_nxt = S_HELD;
          end
        end
      end

      S_HELD: begin
        held_nxt = held_rdata;
        if (func_r == EV_ARRIVE) begin
          if (held_rdata != '0) begin
            // customer already in a room: report it, change nothing
            room_nxt  = held_rdata;
            state_nxt = S_FINISH;
          end else begin
            idx_nxt   = '0;
            map_raddr = '0;
            state_nxt = S_SCAN;
          end
        end else begin
          if (held_rdata == '0) begin
            stat_nxt  = ST_NOROOM;
            state_nxt = S_FINISH;
          end else begin
            map_raddr = MA_W'(((RM_W + 3)'(held_rdata) - (RM_W + 3)'(1)) >> CHUNK_W);
            state_nxt = S_FREE;
          end
        end
      end

      S_SCAN: begin
        // word idx_r is on the read port; fetch the next one meanwhile
        map_raddr = idx_r + MA_W'(1);
        if (pick.found) begin
          map_we     = 1'b1;
          map_waddr  = idx_r;
          map_wdata  = map_rdata | take_bit;
          held_we    = 1'b1;
          held_wdata = new_room;
          room_nxt   = new_room;
          use_nxt    = use_inc;
          if (use_inc > peak_r) begin
            peak_nxt = use_inc;
          end
          state_nxt  = S_FINISH;
        end else if (32'(idx_r) == MAP_D - 1) begin
          stat_nxt  = ST_FULL;
          state_nxt = S_FINISH;
        end else begin
          idx_nxt = idx_r + MA_W'(1);
        end
      end

      S_FREE: begin
        map_we     = 1'b1;
        map_waddr  = free_idx;
        map_wdata  = map_rdata & ~free_bit;
        held_we    = 1'b1;
        held_wdata = '0;
        room_nxt   = held_r;
        if (use_r != '0) begin
          use_nxt = use_r - RM_W'(1);
        end
        state_nxt  = S_FINISH;
      end

      S_FINISH: begin
        // hand over once the output register is free
        if (!ovalid_r || !out_stall) begin
          ovalid_nxt          = 1'b1;
          odata_nxt.room      = 9'(room_r);
          odata_nxt.occupancy = 9'(use_r);
          odata_nxt.peak      = 9'(peak_r);
          odata_nxt.status    = stat_r;
          state_nxt           = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/lfra_checker.sv
// ----------------------------------------------------------------------------
// lfra_checker
// Port-level checks for the lowest free room allocator, bound to the top level.
// ----------------------------------------------------------------------------
module lfra_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input lfra_pkg::out_t out_data
);
  import lfra_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one transaction at a time: busy right after an accept
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a transaction is in work");

  // the peak never trails the occupancy
  a_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.peak >= out_data.occupancy)
    else $error("peak below occupancy");

  // a failed event names no room
  a_fail_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> out_data.room == '0)
    else $error("failed event reports a room");

endmodule

bind lowest_free_room_allocator lfra_checker u_lfra_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: sim/lowest_free_room_allocator_test.sv
// ----------------------------------------------------------------------------
// lowest_free_room_allocator_test
// Self-checking regression for the room allocator: drives arrival and
// departure events under random idling and a long output hold-off, keeps its
// own copy of the free map and the guest table, and checks every result.
// ----------------------------------------------------------------------------
module lowest_free_room_allocator_test;
  import lfra_pkg::*;

  localparam int ROOMS         = 256;
  localparam int CUSTOMERS     = 256;
  // clearing pass, ~900 transactions with the deepest search and random stalls,
  // plus the hold-off, taken many times over
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_OFF_LEN  = 300;
  localparam int REPORT_MAX    = 10;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  // idling percentages and hold-off length, changed by the test tasks
  int sender_idle_pct   = 0;
  int receiver_idle_pct = 0;
  int hold_cycles       = 0;

  int cycle_count    = 0;
  int mismatch_count = 0;

  // local copy of the allocator state
  bit   [ROOMS-1:0] free_rooms;
  logic [8:0]       room_of [CUSTOMERS];
  logic [8:0]       rooms_in_use;
  logic [8:0]       peak_in_use;

  // receipts still owed by the block, oldest first
  out_t receipt_q[$];

  lowest_free_room_allocator #(
    .ROOMS     (ROOMS),
    .CUSTOMERS (CUSTOMERS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lowest_free_room_allocator regression: fail");
      $finish;
    end
  end

  // applies one event to the local state and returns the receipt it yields
  function automatic out_t book_event(input event_t ev, input logic [7:0] cust);
    out_t rcpt;
    int   slot;
    rcpt.room   = '0;
    rcpt.status = ST_OK;
    slot        = ROOMS;
    if (int'(cust) >= CUSTOMERS) begin
      // no record for this customer, ignored
      rcpt.status = ST_NOROOM;
    end else if (ev == EV_ARRIVE) begin
      if (room_of[cust] != '0) begin
        // repeated arrival reports the room already held
        rcpt.room = room_of[cust];
      end else begin
        // lowest free room wins
        for (int k = ROOMS - 1; k >= 0; k--) begin
          if (free_rooms[k]) slot = k;
        end
        if (slot == ROOMS) begin
          rcpt.status = ST_FULL;
        end else begin
          free_rooms[slot] = 1'b0;
          room_of[cust]    = 9'(slot + 1);
          rcpt.room        = 9'(slot + 1);
          rooms_in_use     = rooms_in_use + 9'd1;
          if (rooms_in_use > peak_in_use) peak_in_use = rooms_in_use;
        end
      end
    end else begin
      if (room_of[cust] == '0) begin
        rcpt.status = ST_NOROOM;
      end else begin
        rcpt.room                      = room_of[cust];
        free_rooms[room_of[cust] - 1]  = 1'b1;
        room_of[cust]                  = '0;
        if (rooms_in_use != '0) rooms_in_use = rooms_in_use - 9'd1;
      end
    end
    rcpt.occupancy = rooms_in_use;
    rcpt.peak      = peak_in_use;
    return rcpt;
  endfunction

  // a random customer that holds a room (holder) or holds none, -1 if none
  function automatic int find_guest(input bit holder);
    int start;
    int c;
    start = $urandom_range(0, CUSTOMERS - 1);
    for (int i = 0; i < CUSTOMERS; i++) begin
      c = (start + i) % CUSTOMERS;
      if ((room_of[c] != '0) == holder) return c;
    end
    return -1;
  endfunction

  // offers one transaction, idling first at random, and books it on acceptance
  task automatic send_event(input event_t ev, input logic [7:0] cust);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{func: ev, customer: cust};
    do @(posedge clk); while (in_stall);
    receipt_q = {receipt_q, book_event(ev, cust)};
  endtask

  // lowers valid so that the last transaction is not taken twice
  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // receiver: long hold-off when asked, random stalls otherwise
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
    end
  end

  // compares each accepted result with the oldest receipt owed
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (receipt_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected result: room %0d occupancy %0d peak %0d status %0d",
                   out_data.room, out_data.occupancy, out_data.peak, out_data.status);
      end else begin
        want = receipt_q.pop_front();
        if (out_data.room !== want.room || out_data.occupancy !== want.occupancy ||
            out_data.peak !== want.peak || out_data.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("mismatch exp/act: room %0d/%0d occ %0d/%0d peak %0d/%0d st %0d/%0d",
                     want.room, out_data.room, want.occupancy, out_data.occupancy,
                     want.peak, out_data.peak, want.status, out_data.status);
        end
      end
    end
  end

  // extremes of the customer index, repeated arrival, departure without a room,
  // reuse of the lowest freed room, peak kept after occupancy falls
  task automatic test_directed();
    send_event(EV_ARRIVE, 8'd0);
    send_event(EV_ARRIVE, 8'd255);
    send_event(EV_ARRIVE, 8'd0);
    send_event(EV_DEPART, 8'd128);
    send_event(EV_DEPART, 8'd0);
    send_event(EV_ARRIVE, 8'd170);
    send_event(EV_ARRIVE, 8'd85);
    send_event(EV_DEPART, 8'd255);
    send_event(EV_DEPART, 8'd255);
    send_event(EV_ARRIVE, 8'd1);
    send_event(EV_ARRIVE, 8'd254);
    send_event(EV_DEPART, 8'd170);
    send_event(EV_DEPART, 8'd85);
    send_event(EV_ARRIVE, 8'd2);
    send_event(EV_DEPART, 8'd1);
    send_event(EV_DEPART, 8'd254);
    send_event(EV_DEPART, 8'd2);
    send_event(EV_DEPART, 8'd0);
    send_event(EV_ARRIVE, 8'd127);
    send_event(EV_ARRIVE, 8'd128);
    release_input();
  endtask

  // every customer checks in until all rooms are taken, so the search runs
  // through the whole free map, then half of them leave in random order
  task automatic test_full_house();
    int c;
    for (int n = 0; n < CUSTOMERS; n++) begin
      c = find_guest(1'b0);
      if (c >= 0) send_event(EV_ARRIVE, 8'(c));
    end
    // house full: arrivals only report the rooms already held
    for (int n = 0; n < 4; n++) send_event(EV_ARRIVE, 8'($urandom_range(0, 255)));
    for (int n = 0; n < CUSTOMERS / 2; n++) begin
      c = find_guest(1'b1);
      if (c >= 0) send_event(EV_DEPART, 8'(c));
    end
    release_input();
  endtask

  // mostly well-formed check-ins and check-outs around a drifting occupancy
  // target, with some random events mixed in
  task automatic run_traffic(input int count);
    int  target;
    int  roll;
    int  c;
    bit  arrive;
    target = 0;
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) target = $urandom_range(0, ROOMS);
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        send_event($urandom_range(0, 1) ? EV_DEPART : EV_ARRIVE,
                   8'($urandom_range(0, 255)));
      end else begin
        arrive = (int'(rooms_in_use) < target) ? (roll < 75) : (roll < 35);
        c = find_guest(!arrive);
        if (c < 0) begin
          arrive = !arrive;
          c      = find_guest(!arrive);
        end
        send_event(arrive ? EV_ARRIVE : EV_DEPART, 8'(c));
      end
    end
  endtask

  // three idling patterns in turn
  task automatic test_random_traffic();
    sender_idle_pct   = 12;
    receiver_idle_pct = 61;
    run_traffic(140);
    sender_idle_pct   = 61;
    receiver_idle_pct = 12;
    run_traffic(140);
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    run_traffic(140);
    release_input();
  endtask

  // receiver holds off for a long stretch while the sender keeps offering,
  // so the output register fills and the block stalls its input
  task automatic test_output_hold_off();
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    @(posedge clk);
    hold_cycles = HOLD_OFF_LEN;
    run_traffic(40);
    release_input();
  endtask

  initial begin
    free_rooms   = '1;
    rooms_in_use = '0;
    peak_in_use  = '0;
    for (int i = 0; i < CUSTOMERS; i++) room_of[i] = '0;
    sender_idle_pct   = 12;
    receiver_idle_pct = 61;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_full_house();
    test_random_traffic();
    test_output_hold_off();

    // drain: let every owed receipt arrive, then allow for stray results
    receiver_idle_pct = 0;
    while (receipt_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    mismatch_count += receipt_q.size();

    if (mismatch_count == 0) begin
      $display("lowest_free_room_allocator regression: pass");
    end else begin
      $display("lowest_free_room_allocator regression: fail");
    end
    $finish;
  end

endmodule
